FILE: sv/remaining_size_priority_queue_core_macros.svh
// Assertion macros for the remaining-size priority queue.
// Used by the top level only; depends on nothing else.
`ifndef REMAINING_SIZE_PRIORITY_QUEUE_CORE_MACROS_SVH
`define REMAINING_SIZE_PRIORITY_QUEUE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RSPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/rspq_pkg.sv
// Shared types and codes for the remaining-size priority queue.
// Used by every module of the block; depends on nothing.
package rspq_pkg;

    localparam int DATA_W = 32;

    // Action codes carried by the command word.
    localparam logic [1:0] ACT_BEFORE  = 2'd0;
    localparam logic [1:0] ACT_AFTER   = 2'd1;
    localparam logic [1:0] ACT_APPEND  = 2'd2;
    localparam logic [1:0] ACT_EXTRACT = 2'd3;

    // Status codes carried by the response word.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Size fields of one queue entry.
    typedef struct packed {
        logic [DATA_W-1:0] total;
        logic [DATA_W-1:0] loaded;
    } entry_t;

    // Result of the shared key unit.
    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic              hit;
    } key_res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_KEY,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_WRITE,
        S_HEAD_RD,
        S_HEAD_CAP,
        S_PULL_RD,
        S_PULL_WR,
        S_FIN
    } state_t;

endpackage

FILE: sv/rspq_key_unit.sv
// Shared key unit: saturating remaining-bytes subtract and ordering compare.
// Depends on rspq_pkg.
module rspq_key_unit
    import rspq_pkg::*;
(
    input  entry_t              item,
    input  logic [DATA_W-1:0]   key,
    input  logic                after_ties,
    output key_res_t            result
);

    logic [DATA_W-1:0] rem;

    // Remaining bytes clamp at zero when more was downloaded than the total.
    assign rem = (item.total > item.loaded) ? (item.total - item.loaded) : '0;

    assign result.rem = rem;
    assign result.hit = after_ties ? (rem > key) : (rem >= key);

endmodule

FILE: sv/rspq_mem.sv
// Slot memory of the queue: one write port and one registered read port.
// Depends on rspq_pkg.
module rspq_mem
    import rspq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int TAG_W = 16
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [TAG_W-1:0]         wr_tag,
    input  entry_t                   wr_item,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [TAG_W-1:0]         rd_tag,
    output entry_t                   rd_item
);

    logic [TAG_W-1:0] tag_mem  [DEPTH];
    entry_t           item_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tag_mem[wr_addr]  <= wr_tag;
            item_mem[wr_addr] <= wr_item;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_tag  <= tag_mem[rd_addr];
        rd_item <= item_mem[rd_addr];
    end

endmodule

FILE: sv/remaining_size_priority_queue_core.sv
// Bounded priority queue of download entries keyed by remaining bytes (total size minus
// downloaded bytes, clamped at zero). An ordered insert goes ahead of the first entry, from
// the head, whose key is larger than its own (or equal, for ACT_BEFORE), else to the tail;
// an append goes to the tail, so only ordered inserts keep the smallest key at the head.
// Entries live in a slot memory with one write port and one registered read port, and a
// small sequencer walks it one slot per access while one shared key unit does every
// subtract and compare. cmd_stall stays high from the accepted command word until its
// response is loaded. An extract reads the head, then moves each remaining entry one slot
// toward the head with a read and a write. An ordered insert reads and compares slots from
// the head until the slot is found, moves each later entry back one slot with a read and a
// write, last entry first, and writes the new entry; an append writes it at the tail. A
// finished response sits in an output register, so a new command is taken while the
// previous response still waits on rsp_stall. Full inserts and empty extracts change
// nothing and report their status with zero payload.
// Depends on rspq_pkg, rspq_key_unit, rspq_mem and the assertion macro header.
`include "remaining_size_priority_queue_core_macros.svh"

module remaining_size_priority_queue_core
    import rspq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    // Command channel.
    input  logic                               cmd_valid,
    output logic                               cmd_stall,
    input  logic [1:0]                         action,
    input  logic [TAG_BITS-1:0]                entry_tag,
    input  logic [DATA_W-1:0]                  total_size,
    input  logic [DATA_W-1:0]                  downloaded_bytes,
    // Response channel.
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output logic [1:0]                         status,
    output logic [TAG_BITS-1:0]                out_tag,
    output logic [DATA_W-1:0]                  out_size,
    output logic [DATA_W-1:0]                  out_downloaded,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   entry_count
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Control state.
    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  rsp_valid_reg, rsp_valid_next;

    // Working registers of the command in progress.
    logic [1:0]            act_reg, act_next;
    logic [TAG_BITS-1:0]   tag_reg, tag_next;
    entry_t                item_reg, item_next;
    logic [DATA_W-1:0]     key_reg, key_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [IDX_W-1:0]      pos_reg, pos_next;
    logic [1:0]            res_status_reg, res_status_next;
    logic [TAG_BITS-1:0]   res_tag_reg, res_tag_next;
    entry_t                res_item_reg, res_item_next;

    // Output register.
    logic [1:0]            status_reg, status_next;
    logic [TAG_BITS-1:0]   out_tag_reg, out_tag_next;
    entry_t                out_item_reg, out_item_next;
    logic [CNT_W-1:0]      out_count_reg, out_count_next;

    // Memory and key unit hookup.
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [TAG_BITS-1:0]   wr_tag;
    entry_t                wr_item;
    logic [IDX_W-1:0]      rd_addr;
    logic [TAG_BITS-1:0]   rd_tag;
    entry_t                rd_item;
    entry_t                ku_item;
    key_res_t              ku_res;

    rspq_mem #(
        .DEPTH (QUEUE_DEPTH),
        .TAG_W (TAG_BITS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_tag  (wr_tag),
        .wr_item (wr_item),
        .rd_addr (rd_addr),
        .rd_tag  (rd_tag),
        .rd_item (rd_item)
    );

    rspq_key_unit u_key (
        .item       (ku_item),
        .key        (key_reg),
        .after_ties (act_reg == ACT_AFTER),
        .result     (ku_res)
    );

    assign cmd_stall      = (state_reg != S_IDLE);
    assign rsp_valid      = rsp_valid_reg;
    assign status         = status_reg;
    assign out_tag        = out_tag_reg;
    assign out_size       = out_item_reg.total;
    assign out_downloaded = out_item_reg.loaded;
    assign entry_count    = out_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        tag_reg        <= tag_next;
        item_reg       <= item_next;
        key_reg        <= key_next;
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        res_status_reg <= res_status_next;
        res_tag_reg    <= res_tag_next;
        res_item_reg   <= res_item_next;
        status_reg     <= status_next;
        out_tag_reg    <= out_tag_next;
        out_item_reg   <= out_item_next;
        out_count_reg  <= out_count_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        act_next        = act_reg;
        tag_next        = tag_reg;
        item_next       = item_reg;
        key_next        = key_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        res_status_next = res_status_reg;
        res_tag_next    = res_tag_reg;
        res_item_next   = res_item_reg;
        status_next     = status_reg;
        out_tag_next    = out_tag_reg;
        out_item_next   = out_item_reg;
        out_count_next  = out_count_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_tag          = tag_reg;
        wr_item         = item_reg;
        rd_addr         = idx_reg;
        ku_item         = item_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    act_next        = action;
                    tag_next        = entry_tag;
                    item_next.total = total_size;
                    item_next.loaded = downloaded_bytes;
                    res_status_next = ST_DONE;
                    res_tag_next    = '0;
                    res_item_next   = '0;
                    if (action == ACT_EXTRACT)
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            state_next = S_HEAD_RD;
                        end
                    end
                    else if (count_reg == CNT_W'(QUEUE_DEPTH))
                    begin
                        res_status_next = ST_FULL;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        state_next = S_KEY;
                    end
                end
            end

            S_KEY:
            begin
                // The key unit works on the new word here and on slots during the scan.
                key_next = ku_res.rem;
                idx_next = '0;
                if (act_reg == ACT_APPEND || count_reg == '0)
                begin
                    pos_next   = IDX_W'(count_reg);
                    state_next = S_WRITE;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end

            S_SCAN_RD:
            begin
                state_next = S_SCAN_CMP;
            end

            S_SCAN_CMP:
            begin
                ku_item = rd_item;
                if (ku_res.hit)
                begin
                    // Open a gap at this slot by moving the tail back, last entry first.
                    pos_next   = idx_reg;
                    idx_next   = IDX_W'(count_reg - CNT_W'(1));
                    state_next = S_SHIFT_RD;
                end
                else if ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg)
                begin
                    pos_next   = IDX_W'(count_reg);
                    state_next = S_WRITE;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_SCAN_RD;
                end
            end

            S_SHIFT_RD:
            begin
                state_next = S_SHIFT_WR;
            end

            S_SHIFT_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg + IDX_W'(1);
                wr_tag  = rd_tag;
                wr_item = rd_item;
                if (idx_reg == pos_reg)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    idx_next   = idx_reg - IDX_W'(1);
                    state_next = S_SHIFT_RD;
                end
            end

            S_WRITE:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = S_FIN;
            end

            S_HEAD_RD:
            begin
                rd_addr    = '0;
                state_next = S_HEAD_CAP;
            end

            S_HEAD_CAP:
            begin
                res_tag_next  = rd_tag;
                res_item_next = rd_item;
                count_next    = count_reg - CNT_W'(1);
                idx_next      = IDX_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_PULL_RD;
                end
            end

            S_PULL_RD:
            begin
                state_next = S_PULL_WR;
            end

            S_PULL_WR:
            begin
                // Each remaining entry moves one slot toward the head.
                wr_en   = 1'b1;
                wr_addr = idx_reg - IDX_W'(1);
                wr_tag  = rd_tag;
                wr_item = rd_item;
                if (CNT_W'(idx_reg) == count_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_PULL_RD;
                end
            end

            S_FIN:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    out_tag_next   = res_tag_reg;
                    out_item_next  = res_item_reg;
                    out_count_next = count_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `RSPQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1,
        count_reg <= CNT_W'(QUEUE_DEPTH), "held count exceeds queue depth")
    `RSPQ_ASSERT_NEXT(a_accept_busy, clk, rst_n, cmd_valid && !cmd_stall,
        state_reg != S_IDLE, "sequencer idle after accepting a word")
    `RSPQ_ASSERT_NOW(a_empty_word, clk, rst_n, rsp_valid && status == ST_EMPTY,
        entry_count == '0 && out_tag == '0 && out_size == '0,
        "empty response with payload or entries")
    `RSPQ_ASSERT_NOW(a_full_word, clk, rst_n, rsp_valid && status == ST_FULL,
        entry_count == CNT_W'(QUEUE_DEPTH), "full response while queue not full")

endmodule

FILE: tb/remaining_size_priority_queue_core_test.sv
// Self-checking testbench for the remaining-size priority queue core.
// Needs rspq_pkg and the core RTL; drives directed and random command words and
// checks every response word against a queue model kept in this file or the directed table.
`timescale 1ns / 100ps

module remaining_size_priority_queue_core_test
    import rspq_pkg::*;
();

    localparam int QUEUE_DEPTH  = 16;
    localparam int TAG_BITS     = 16;
    localparam int COUNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 12;
    // The slowest command is an ordered insert into a nearly full queue. The settling wait
    // at the end, after every owed response has come out, watches for extra response words.
    localparam int DRAIN_CYCLES = 100;
    // Length of the one long receiver hold-off that backs up the command side.
    localparam int HOLD_CYCLES  = 300;
    localparam int LIMIT_NS     = 10_000_000;
    localparam int MAX_REPORTS  = 40;
    localparam int PHASE_ITEMS  = 400;
    localparam int BLOCK_ITEMS  = 40;

    localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};

    // Directed rows are either checked against the model or carry their own answer.
    localparam logic BY_MODEL = 1'b0;
    localparam logic BY_TABLE = 1'b1;

    // One command word as seen on the input ports.
    typedef struct packed {
        logic [1:0]          action;
        logic [TAG_BITS-1:0] tag;
        logic [DATA_W-1:0]   total;
        logic [DATA_W-1:0]   loaded;
    } cmd_word_t;

    // One response word as seen on the output ports.
    typedef struct packed {
        logic [1:0]          status;
        logic [TAG_BITS-1:0] tag;
        logic [DATA_W-1:0]   size;
        logic [DATA_W-1:0]   loaded;
        logic [COUNT_W-1:0]  count;
    } response_t;

    typedef struct packed {
        cmd_word_t cmd;
        logic      from_table;
        response_t rsp;
    } directed_row_t;

    // The directed table. The first rows fill the queue from empty to full while
    // hitting the field extremes, saturated keys, ties on both sides of the two
    // ordered inserts and appends that leave the queue out of order. Then every
    // insert kind is tried on a full queue, and a few extracts pull the head.
    directed_row_t directed_rows [24] = '{
        // Extract on an empty queue: nothing changes, payload is zero.
        '{'{ACT_EXTRACT, 16'hFFFF, ALL_ONES, ALL_ONES},
          BY_TABLE, '{ST_EMPTY, 16'h0, 32'h0, 32'h0, 5'd0}},
        // Largest possible key, then a key saturated to zero.
        '{'{ACT_BEFORE, 16'hFFFF, ALL_ONES, 32'h0},
          BY_TABLE, '{ST_DONE, 16'h0, 32'h0, 32'h0, 5'd1}},
        '{'{ACT_AFTER, 16'h0000, 32'h0, ALL_ONES},
          BY_TABLE, '{ST_DONE, 16'h0, 32'h0, 32'h0, 5'd2}},
        // Zero-key ties, placed ahead of and behind the existing zero key.
        '{'{ACT_BEFORE, 16'h0001, 32'd5, 32'd5},            BY_MODEL, '0},
        '{'{ACT_AFTER, 16'h0002, 32'd10, 32'd20},           BY_MODEL, '0},
        // An append behind the largest key leaves the queue unsorted.
        '{'{ACT_APPEND, 16'h0003, 32'd1, 32'd0},            BY_MODEL, '0},
        '{'{ACT_BEFORE, 16'h0004, 32'd150, 32'd50},         BY_MODEL, '0},
        '{'{ACT_AFTER, 16'h0005, 32'd100, 32'd0},           BY_MODEL, '0},
        '{'{ACT_BEFORE, 16'h0006, 32'd1100, 32'd1000},      BY_MODEL, '0},
        '{'{ACT_AFTER, 16'h0007, ALL_ONES, 32'h0},          BY_MODEL, '0},
        '{'{ACT_BEFORE, 16'h0008, ALL_ONES, 32'h1},         BY_MODEL, '0},
        '{'{ACT_APPEND, 16'hAAAA, 32'hAAAA_AAAA, 32'h5555_5555}, BY_MODEL, '0},
        '{'{ACT_BEFORE, 16'h5555, 32'h5555_5555, 32'hAAAA_AAAA}, BY_MODEL, '0},
        '{'{ACT_AFTER, 16'h8000, 32'h8000_0000, 32'h7FFF_FFFF},  BY_MODEL, '0},
        '{'{ACT_BEFORE, 16'h7FFF, 32'h7FFF_FFFF, 32'h0},    BY_MODEL, '0},
        '{'{ACT_AFTER, 16'h1234, 32'd2, 32'd1},             BY_MODEL, '0},
        // The sixteenth entry fills the queue.
        '{'{ACT_APPEND, 16'h4321, 32'h0, 32'h0},            BY_MODEL, '0},
        // Every insert kind on a full queue is refused.
        '{'{ACT_BEFORE, 16'h0009, 32'd3, 32'd0},
          BY_TABLE, '{ST_FULL, 16'h0, 32'h0, 32'h0, 5'd16}},
        '{'{ACT_APPEND, 16'h000A, 32'd3, 32'd0},
          BY_TABLE, '{ST_FULL, 16'h0, 32'h0, 32'h0, 5'd16}},
        '{'{ACT_AFTER, 16'h000B, 32'd3, 32'd0},
          BY_TABLE, '{ST_FULL, 16'h0, 32'h0, 32'h0, 5'd16}},
        '{'{ACT_EXTRACT, 16'h0, 32'h0, 32'h0},              BY_MODEL, '0},
        '{'{ACT_EXTRACT, 16'hFFFF, ALL_ONES, ALL_ONES},     BY_MODEL, '0},
        '{'{ACT_EXTRACT, 16'h0, 32'h0, 32'h0},              BY_MODEL, '0},
        '{'{ACT_EXTRACT, 16'h0, 32'h0, 32'h0},              BY_MODEL, '0}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                cmd_valid = 1'b0;
    logic                cmd_stall;
    logic [1:0]          action = ACT_BEFORE;
    logic [TAG_BITS-1:0] entry_tag = '0;
    logic [DATA_W-1:0]   total_size = '0;
    logic [DATA_W-1:0]   downloaded_bytes = '0;

    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    logic [1:0]          status;
    logic [TAG_BITS-1:0] out_tag;
    logic [DATA_W-1:0]   out_size;
    logic [DATA_W-1:0]   out_downloaded;
    logic [COUNT_W-1:0]  entry_count;

    // Queue model: slot 0 is the head, slots below model_count are valid.
    logic [TAG_BITS-1:0] model_tag    [QUEUE_DEPTH];
    logic [DATA_W-1:0]   model_total  [QUEUE_DEPTH];
    logic [DATA_W-1:0]   model_loaded [QUEUE_DEPTH];
    int                  model_count = 0;

    // Response words still owed by the block, oldest first.
    response_t pending_responses [$];

    // Idling for the current phase, in percent of cycles.
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    // Bumped by the stimulus to ask the receiver for one long hold-off.
    int hold_requests = 0;
    int mismatch_count = 0;

    remaining_size_priority_queue_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd_valid        (cmd_valid),
        .cmd_stall        (cmd_stall),
        .action           (action),
        .entry_tag        (entry_tag),
        .total_size       (total_size),
        .downloaded_bytes (downloaded_bytes),
        .rsp_valid        (rsp_valid),
        .rsp_stall        (rsp_stall),
        .status           (status),
        .out_tag          (out_tag),
        .out_size         (out_size),
        .out_downloaded   (out_downloaded),
        .entry_count      (entry_count)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Remaining bytes of a download, never below zero.
    function automatic logic [DATA_W-1:0] remaining_bytes(input logic [DATA_W-1:0] total,
                                                          input logic [DATA_W-1:0] loaded);
        return (total > loaded) ? total - loaded : '0;
    endfunction

    // Applies one accepted command word to the queue model and returns the
    // response word that the block has to give for it.
    function automatic response_t predict_queue_response(input cmd_word_t word);
        response_t         rsp;
        logic [DATA_W-1:0] new_key;
        logic [DATA_W-1:0] held_key;
        int                slot;
        rsp = '0;
        rsp.status = ST_DONE;
        if (word.action == ACT_EXTRACT)
        begin
            if (model_count == 0)
            begin
                rsp.status = ST_EMPTY;
            end
            else
            begin
                rsp.tag = model_tag[0];
                rsp.size = model_total[0];
                rsp.loaded = model_loaded[0];
                for (int i = 1; i < model_count; i++)
                begin
                    model_tag[i - 1] = model_tag[i];
                    model_total[i - 1] = model_total[i];
                    model_loaded[i - 1] = model_loaded[i];
                end
                model_count--;
            end
        end
        else if (model_count >= QUEUE_DEPTH)
        begin
            rsp.status = ST_FULL;
        end
        else
        begin
            // The ordered inserts take the first slot, counted from the head,
            // whose key beats the new one; ties go ahead for one kind and behind
            // for the other. The scan does not care whether the queue is sorted.
            new_key = remaining_bytes(word.total, word.loaded);
            slot = model_count;
            if (word.action != ACT_APPEND)
            begin
                for (int i = 0; i < model_count; i++)
                begin
                    held_key = remaining_bytes(model_total[i], model_loaded[i]);
                    if (slot == model_count &&
                        ((word.action == ACT_AFTER) ? held_key > new_key : held_key >= new_key))
                    begin
                        slot = i;
                    end
                end
            end
            for (int i = model_count; i > slot; i--)
            begin
                model_tag[i] = model_tag[i - 1];
                model_total[i] = model_total[i - 1];
                model_loaded[i] = model_loaded[i - 1];
            end
            model_tag[slot] = word.tag;
            model_total[slot] = word.total;
            model_loaded[slot] = word.loaded;
            model_count++;
        end
        rsp.count = COUNT_W'(model_count);
        return rsp;
    endfunction

    // Picks the two size fields of a random word. Small values give many equal
    // keys and saturated ones; the rest spread over the whole range and its edges.
    function automatic void pick_sizes(output logic [DATA_W-1:0] total,
                                       output logic [DATA_W-1:0] loaded);
        int mode;
        mode = $urandom_range(99);
        if (mode < 40)
        begin
            total = $urandom_range(12);
            loaded = $urandom_range(8);
        end
        else if (mode < 65)
        begin
            total = $urandom;
            loaded = $urandom;
        end
        else if (mode < 80)
        begin
            // Downloaded count at or above the size, so the key saturates.
            loaded = $urandom;
            total = loaded >> $urandom_range(31);
        end
        else
        begin
            case ($urandom_range(3))
                0: total = '0;
                1: total = ALL_ONES;
                2: total = 32'h8000_0000;
                default: total = 32'h1;
            endcase
            case ($urandom_range(2))
                0: loaded = '0;
                1: loaded = ALL_ONES;
                default: loaded = total;
            endcase
        end
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t ns: %s", $time, what);
    endtask

    // Offers one command word, holds it steady while the block stalls, and
    // records the expected response once the word is taken.
    task automatic send_word(input cmd_word_t word, input logic from_table,
                             input response_t table_rsp);
        response_t predicted;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        action <= word.action;
        entry_tag <= word.tag;
        total_size <= word.total;
        downloaded_bytes <= word.loaded;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        // The model always advances, even where the table gives the answer.
        predicted = predict_queue_response(word);
        pending_responses.push_back(from_table ? table_rsp : predicted);
    endtask

    // Response side: checks each word taken from the block and decides the
    // stall for the next cycle. A long hold-off, when asked for, is counted
    // here so that the sender keeps offering words while the block backs up.
    initial
    begin : response_checker
        response_t expected;
        int        hold_left;
        int        holds_served;
        hold_left = 0;
        holds_served = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
            begin
                if (pending_responses.size() == 0)
                begin
                    report_mismatch("response word arrived with none expected");
                end
                else
                begin
                    expected = pending_responses.pop_front();
                    if (status !== expected.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  status, expected.status));
                    if (out_tag !== expected.tag)
                        report_mismatch($sformatf("out_tag %h, expected %h",
                                                  out_tag, expected.tag));
                    if (out_size !== expected.size)
                        report_mismatch($sformatf("out_size %h, expected %h",
                                                  out_size, expected.size));
                    if (out_downloaded !== expected.loaded)
                        report_mismatch($sformatf("out_downloaded %h, expected %h",
                                                  out_downloaded, expected.loaded));
                    if (entry_count !== expected.count)
                        report_mismatch($sformatf("entry_count %0d, expected %0d",
                                                  entry_count, expected.count));
                end
            end
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
            end
        end
    end

    // Watchdog for a block that hangs.
    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("remaining_size_priority_queue_core regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        cmd_word_t word;
        int        sender_plan [4];
        int        receiver_plan [4];
        int        insert_pct;
        int        pick;
        // Idling phases: none, sender mostly idle, receiver mostly stalling,
        // and both idling now and then.
        sender_plan = '{0, 78, 0, 27};
        receiver_plan = '{0, 0, 78, 27};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
            send_word(directed_rows[r].cmd, directed_rows[r].from_table, directed_rows[r].rsp);

        // Random part. Each block of words leans toward filling, draining or
        // holding the queue level, so full and empty are both reached often and
        // the ordered inserts work against queues of every length.
        for (int phase = 0; phase < 4; phase++)
        begin
            sender_idle_pct = sender_plan[phase];
            receiver_stall_pct = receiver_plan[phase];
            // With no idling on the sender, one long receiver hold-off lets the
            // output register and then the command side back up.
            if (phase == 0)
                hold_requests++;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % BLOCK_ITEMS == 0)
                begin
                    case ($urandom_range(2))
                        0: insert_pct = 85;
                        1: insert_pct = 50;
                        default: insert_pct = 15;
                    endcase
                end
                if ($urandom_range(99) < insert_pct)
                begin
                    pick = $urandom_range(9);
                    word.action = (pick < 4) ? ACT_BEFORE :
                                  (pick < 8) ? ACT_AFTER : ACT_APPEND;
                end
                else
                begin
                    word.action = ACT_EXTRACT;
                end
                // Extracts get random fields too; the block has to ignore them.
                word.tag = TAG_BITS'($urandom);
                pick_sizes(word.total, word.loaded);
                send_word(word, BY_MODEL, '0);
            end
        end
        cmd_valid <= 1'b0;

        // Let every owed response come out, then watch a little longer for
        // anything extra.
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("remaining_size_priority_queue_core regression: pass");
        else
            $display("remaining_size_priority_queue_core regression: fail");
        $finish;
    end

endmodule
